/* hw/rtl/ffha_pkg.sv */
// Shared types and constants for the first-fit heap allocator.
// Holds the request and response beat structs and the sequencer state type.
// No dependencies.
package ffha_pkg;

    // Fixed widths of the beat fields.
    localparam int ADDR_W  = 12;
    localparam int BYTES_W = 16;

    // Allocation granule in bytes; one header occupies one unit.
    localparam int UNIT_BYTES = 16;
    localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);

    // Width of the rounded byte sum and of the unit count including the header.
    localparam int BSUM_W = BYTES_W + 1;
    localparam int NEED_W = BYTES_W + 1 - UNIT_SHIFT;

    // Request kinds.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [BYTES_W-1:0] request_bytes;
        logic [ADDR_W-1:0]  block_addr;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_addr;
        logic              ok;
    } rsp_t;

    typedef enum logic [3:0] {
        S_INIT0,
        S_INIT1,
        S_IDLE,
        S_A_LINK,
        S_A_TEST,
        S_A_SPLIT,
        S_F_WALK,
        S_F_HDR,
        S_F_NX,
        S_F_LO,
        S_DONE
    } state_t;

endpackage

/* hw/rtl/ffha_heap_store.sv */
// Header store of the heap: a next-link memory and a size memory.
// One shared read address with registered read data, one write port per memory.
// Depends on nothing but its parameters.
module ffha_heap_store #(
    parameter int DEPTH = 4096,
    parameter int IW    = 12,
    parameter int SW    = 13
) (
    input  logic          clk,
    input  logic [IW-1:0] rd_addr,
    output logic [IW-1:0] link_rdata,
    output logic [SW-1:0] size_rdata,
    input  logic          link_we,
    input  logic [IW-1:0] link_waddr,
    input  logic [IW-1:0] link_wdata,
    input  logic          size_we,
    input  logic [IW-1:0] size_waddr,
    input  logic [SW-1:0] size_wdata
);

    logic [IW-1:0] link_mem [DEPTH];
    logic [SW-1:0] size_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata <= link_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (size_we)
        begin
            size_mem[size_waddr] <= size_wdata;
        end
        size_rdata <= size_mem[rd_addr];
    end

endmodule

/* hw/rtl/first_fit_heap_allocator_top.sv */
// First-fit heap allocator: a classic address-ordered free list with a roving pointer,
// kept in on-chip header memories. Every request beat gives exactly one response beat.
// Depends on ffha_pkg and ffha_heap_store.
//
// The arena holds HEAP_UNITS header-sized units of 16 bytes and is wholly free after reset.
// An allocate beat asks for request_bytes; the block rounds this up to whole units, adds one
// header unit and walks the circular free list from the entry after the rover, taking the
// first block that is large enough: all of it on an exact fit, otherwise its tail. The
// response carries the user unit address (header plus one, kept to 12 bits) with ok set, or
// address zero with ok clear when a full lap finds no space. A free beat returns the block
// whose user address is block_addr to the list in address order, merging it with free
// neighbours on either side; it always answers ok with address zero, and addresses 0 and 1
// or headers beyond the arena are ignored. After reset the block writes the base and
// whole-heap headers before it raises in_ready. The walk reads one list entry per cycle
// through the single read port of the header memories. An allocate reads the rover's link,
// tests entries and writes the tail header on a split; a free walks to p, reads the freed
// header and merges the upper, then the lower neighbour. The result sits in an output
// register, so the next request is accepted as soon as the sequencer is idle, even while
// the previous response beat waits for out_ready. One request is in progress at a time.
module first_fit_heap_allocator_top #(
    parameter int HEAP_UNITS = 4096
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ffha_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ffha_pkg::rsp_t out_data
);

    import ffha_pkg::*;

    // Unit index width, stored size width and the widths used for sums and compares.
    localparam int IW  = $clog2(HEAP_UNITS);
    localparam int SW  = IW + 1;
    localparam int SW1 = SW + 1;
    localparam int MW  = (SW > NEED_W) ? SW : NEED_W;
    localparam int SCW = $clog2(HEAP_UNITS + 1);
    localparam int HW  = ((ADDR_W > IW) ? ADDR_W : IW) + 1;

    localparam logic [SW-1:0] HEAP_L = SW'(HEAP_UNITS);

    function automatic logic in_heap(input logic [IW-1:0] idx);
        in_heap = {1'b0, idx} < HEAP_L;
    endfunction

    // Sequencer and datapath registers.
    state_t             state_reg, state_next;
    logic [IW-1:0]      rover_reg, rover_next;
    logic [IW-1:0]      prev_reg, prev_next;    // previous entry, or p during a free
    logic [IW-1:0]      cur_reg, cur_next;      // entry under test, or p's successor
    logic [IW-1:0]      hdr_reg, hdr_next;      // header of the block being freed
    logic [IW-1:0]      linkb_reg, linkb_next;  // link of the freed header after merging
    logic [SW-1:0]      sza_reg, sza_next;      // remainder on a split, or size of p
    logic [SW-1:0]      szb_reg, szb_next;      // size of the freed header
    logic [NEED_W-1:0]  need_reg, need_next;
    logic [SCW-1:0]     step_reg, step_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic               res_ok_reg, res_ok_next;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_data_reg, out_data_next;

    // Header memory port.
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] link_rd;
    logic [SW-1:0] size_rd;
    logic          link_we;
    logic [IW-1:0] link_waddr;
    logic [IW-1:0] link_wdata;
    logic          size_we;
    logic [IW-1:0] size_waddr;
    logic [SW-1:0] size_wdata;

    // Datapath terms.
    logic              accept;
    logic              load;
    logic [BSUM_W-1:0] bytes_sum;
    logic [NEED_W-1:0] req_need;
    logic [ADDR_W-1:0] free_hdr;
    logic              free_skip;
    logic              cur_ok;
    logic              prev_ok;
    logic [SW-1:0]     cur_size;
    logic [IW-1:0]     cur_link;
    logic [IW-1:0]     prev_link;
    logic [SW1-1:0]    end_sum;
    logic              fit;
    logic              exact;
    logic [SW-1:0]     rem;
    logic [IW-1:0]     split_hdr;
    logic [ADDR_W-1:0] grant_exact;
    logic [ADDR_W-1:0] grant_split;
    logic              at_rover;
    logic              last_step;
    logic              found;
    logic              hi_adj;
    logic [SW-1:0]     merged_size;
    logic [IW-1:0]     merged_link;
    logic              lo_adj;
    logic [SW-1:0]     lo_size;

    ffha_heap_store #(
        .DEPTH (HEAP_UNITS),
        .IW    (IW),
        .SW    (SW)
    ) u_store (
        .clk        (clk),
        .rd_addr    (rd_addr),
        .link_rdata (link_rd),
        .size_rdata (size_rd),
        .link_we    (link_we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .size_we    (size_we),
        .size_waddr (size_waddr),
        .size_wdata (size_wdata)
    );

    // Datapath: everything the sequencer decides on.
    always_comb
    begin
        accept = in_valid && in_ready;
        load   = !out_valid_reg || out_ready;

        // Units needed: round the byte count up to whole units and add the header.
        bytes_sum = {1'b0, in_data.request_bytes} + BSUM_W'(UNIT_BYTES - 1);
        req_need  = NEED_W'(bytes_sum >> UNIT_SHIFT) + NEED_W'(1);

        free_hdr  = in_data.block_addr - ADDR_W'(1);
        free_skip = (in_data.block_addr < ADDR_W'(2)) ||
                    (HW'(free_hdr) >= HW'(HEAP_UNITS));

        // Read data belongs to the entry addressed in the previous cycle.
        cur_ok    = in_heap(cur_reg);
        prev_ok   = in_heap(prev_reg);
        cur_size  = cur_ok ? size_rd : '0;
        cur_link  = cur_ok ? link_rd : '0;
        prev_link = prev_ok ? link_rd : '0;

        // Allocate: does the entry under test hold the request and lie inside the arena?
        end_sum   = SW1'(cur_reg) + SW1'(cur_size);
        fit       = cur_ok && (MW'(cur_size) >= MW'(need_reg)) &&
                    (end_sum <= SW1'(HEAP_UNITS));
        exact     = MW'(cur_size) == MW'(need_reg);
        rem       = SW'(MW'(cur_size) - MW'(need_reg));
        split_hdr = IW'(SW1'(cur_reg) + SW1'(sza_reg));
        grant_exact = ADDR_W'(SW'(cur_reg) + SW'(1));
        grant_split = ADDR_W'(SW'(split_hdr) + SW'(1));
        at_rover  = cur_reg == rover_reg;
        last_step = step_reg == SCW'(HEAP_UNITS);

        // Free: the freed header lies between p and its successor, or past the wrap point.
        found = ((hdr_reg > prev_reg) && (hdr_reg < prev_link)) ||
                ((prev_reg >= prev_link) &&
                 ((hdr_reg > prev_reg) || (hdr_reg < prev_link)));

        // Merge with the upper neighbour, whose header was read into cur_size and cur_link.
        hi_adj      = (SW1'(hdr_reg) + SW1'(szb_reg)) == SW1'(cur_reg);
        merged_size = hi_adj ? SW'(SW1'(szb_reg) + SW1'(cur_size)) : szb_reg;
        merged_link = hi_adj ? cur_link : cur_reg;

        // Merge with the lower neighbour p.
        lo_adj  = (SW1'(prev_reg) + SW1'(sza_reg)) == SW1'(hdr_reg);
        lo_size = SW'(SW1'(sza_reg) + SW1'(szb_reg));
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT0:
            begin
                state_next = S_INIT1;
            end
            S_INIT1:
            begin
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.mode == MODE_ALLOC)
                    begin
                        state_next = S_A_LINK;
                    end
                    else if (free_skip)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_F_WALK;
                    end
                end
            end
            S_A_LINK:
            begin
                state_next = S_A_TEST;
            end
            S_A_TEST:
            begin
                if (fit)
                begin
                    state_next = exact ? S_DONE : S_A_SPLIT;
                end
                else if (at_rover || last_step)
                begin
                    state_next = S_DONE;
                end
            end
            S_A_SPLIT:
            begin
                state_next = S_DONE;
            end
            S_F_WALK:
            begin
                if (found)
                begin
                    state_next = prev_ok ? S_F_HDR : S_DONE;
                end
                else if (last_step)
                begin
                    state_next = S_DONE;
                end
            end
            S_F_HDR:
            begin
                state_next = S_F_NX;
            end
            S_F_NX:
            begin
                state_next = S_F_LO;
            end
            S_F_LO:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs: memory port, handshake and register updates.
    always_comb
    begin
        in_ready       = state_reg == S_IDLE;
        rd_addr        = rover_reg;
        link_we        = 1'b0;
        link_waddr     = prev_reg;
        link_wdata     = cur_reg;
        size_we        = 1'b0;
        size_waddr     = cur_reg;
        size_wdata     = rem;
        rover_next     = rover_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        hdr_next       = hdr_reg;
        linkb_next     = linkb_reg;
        sza_next       = sza_reg;
        szb_next       = szb_reg;
        need_next      = need_reg;
        step_next      = step_reg;
        res_addr_next  = res_addr_reg;
        res_ok_next    = res_ok_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            S_INIT0:
            begin
                // Base entry: size zero, linked to the whole-heap block.
                link_we    = 1'b1;
                link_waddr = '0;
                link_wdata = IW'(1);
                size_we    = 1'b1;
                size_waddr = '0;
                size_wdata = '0;
            end
            S_INIT1:
            begin
                link_we    = 1'b1;
                link_waddr = IW'(1);
                link_wdata = '0;
                size_we    = 1'b1;
                size_waddr = IW'(1);
                size_wdata = SW'(HEAP_UNITS - 1);
            end
            S_IDLE:
            begin
                // The rover's header is read here so the walk can start next cycle.
                if (accept)
                begin
                    prev_next     = rover_reg;
                    step_next     = '0;
                    need_next     = req_need;
                    hdr_next      = IW'(free_hdr);
                    res_addr_next = '0;
                    res_ok_next   = 1'b1;
                end
            end
            S_A_LINK:
            begin
                cur_next = prev_link;
                rd_addr  = prev_link;
            end
            S_A_TEST:
            begin
                if (fit)
                begin
                    rover_next = prev_reg;
                    if (exact)
                    begin
                        link_we       = prev_ok;
                        link_waddr    = prev_reg;
                        link_wdata    = link_rd;
                        res_addr_next = grant_exact;
                        res_ok_next   = 1'b1;
                    end
                    else
                    begin
                        size_we    = 1'b1;
                        size_waddr = cur_reg;
                        size_wdata = rem;
                        sza_next   = rem;
                    end
                end
                else if (at_rover || last_step)
                begin
                    res_addr_next = '0;
                    res_ok_next   = 1'b0;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = cur_link;
                    rd_addr   = cur_link;
                    step_next = step_reg + SCW'(1);
                end
            end
            S_A_SPLIT:
            begin
                // The tail of the block becomes the granted block.
                size_we       = 1'b1;
                size_waddr    = split_hdr;
                size_wdata    = SW'(need_reg);
                res_addr_next = grant_split;
                res_ok_next   = 1'b1;
            end
            S_F_WALK:
            begin
                if (found)
                begin
                    cur_next = prev_link;
                    sza_next = size_rd;
                    rd_addr  = hdr_reg;
                end
                else if (!last_step)
                begin
                    prev_next = prev_link;
                    rd_addr   = prev_link;
                    step_next = step_reg + SCW'(1);
                end
            end
            S_F_HDR:
            begin
                szb_next = size_rd;
                rd_addr  = cur_reg;
            end
            S_F_NX:
            begin
                link_we    = 1'b1;
                link_waddr = hdr_reg;
                link_wdata = merged_link;
                size_we    = 1'b1;
                size_waddr = hdr_reg;
                size_wdata = merged_size;
                szb_next   = merged_size;
                linkb_next = merged_link;
            end
            S_F_LO:
            begin
                link_we    = 1'b1;
                link_waddr = prev_reg;
                link_wdata = lo_adj ? linkb_reg : hdr_reg;
                size_we    = lo_adj;
                size_waddr = prev_reg;
                size_wdata = lo_size;
                rover_next = prev_reg;
            end
            S_DONE:
            begin
                if (load)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.result_addr = res_addr_reg;
                    out_data_next.ok          = res_ok_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT0;
            rover_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rover_reg     <= rover_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        hdr_reg      <= hdr_next;
        linkb_reg    <= linkb_next;
        sza_reg      <= sza_next;
        szb_reg      <= szb_next;
        need_reg     <= need_next;
        step_reg     <= step_next;
        res_addr_reg <= res_addr_next;
        res_ok_reg   <= res_ok_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The rover always names an entry inside the arena.
    a_rover_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, rover_reg} < HEAP_L)
        else $error("rover left the arena");

    // A refused allocation never carries an address.
    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.ok) |-> (out_data.result_addr == '0))
        else $error("failed response carries an address");

    // The list walk never runs past its lap bound.
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_A_TEST || state_reg == S_F_WALK) |-> (step_reg <= SCW'(HEAP_UNITS)))
        else $error("list walk exceeded its bound");

    // Size writes during a request stay inside the arena.
    a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        (size_we && state_reg != S_INIT0 && state_reg != S_INIT1) |->
        ({1'b0, size_waddr} < HEAP_L))
        else $error("size write outside the arena");

    // A response is loaded only when the previous beat has gone or is leaving.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=>
        (state_reg == S_DONE && $stable(out_data_reg)))
        else $error("pending response overwritten");

endmodule
